/* sv/life_generation_stream_unit_assert.svh */
// Assertion macros used by the checker file of the life generation stream unit.
`ifndef LIFE_GENERATION_STREAM_UNIT_ASSERT_SVH
`define LIFE_GENERATION_STREAM_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgs: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgs: next-cycle check failed");

`endif

/* sv/lgs_pkg.sv */
// Shared types and constants of the life generation stream unit.
package lgs_pkg;

  localparam int GRID_WIDTH_W  = 9;
  localparam int GRID_HEIGHT_W = 13;
  localparam int OUT_ROW_W     = 12;
  localparam int OUT_COL_W     = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_PAD_W     = 3;
  localparam int OUT_TDATA_W   = 1 + OUT_ROW_W + OUT_COL_W + OUT_PAD_W;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int STORE_W       = 2;

  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 9'd80;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 13'd24;

  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic push;
    logic clear;
    logic first_col;
    logic left_ok;
    logic wide;
  } win_ctl_t;

endpackage

/* sv/life_generation_stream_unit.sv */
// Top level of the life generation stream unit with control, configuration and output buffer.
// Computes one B3/S23 generation of a grid streamed in raster order, one cell per item, with
// dead cells outside the grid. The unit takes one item per clock while in_tready is high; the row
// store is a chain of MAX_WIDTH cells tapped at the grid width, so every neighbor is at hand
// without stalls. Each result leaves one row plus one cell after its cell, and flush items on
// in_tuser drain the last row plus one cell after the frame's final cell. For a frame of a single
// row, in_tready drops for one cycle after the final cell while a dead cell is pushed internally.
// A two-entry output buffer keeps in_tready high while one result waits on out_tready.
module life_generation_stream_unit import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] cell_alive, [7:1] zero
  input  logic [0:0]             in_tuser,   // [0] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] next_alive, [12:1] out_row, [20:13] out_col
  output logic                   out_tlast   // frame_end
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int PW = $clog2(MAX_WIDTH + 2);

  logic [GRID_WIDTH_W-1:0]  grid_width_r;
  logic [GRID_HEIGHT_W-1:0] grid_height_r;
  logic [CW-1:0]            col_r;
  logic [CW-1:0]            col_nxt;
  logic [RW-1:0]            row_r;
  logic [RW-1:0]            row_nxt;
  logic [PW-1:0]            pend_r;
  logic [PW-1:0]            pend_nxt;
  logic                     bubble_r;
  logic                     bubble_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TDATA_W-1:0]   out_data_nxt;
  logic                     out_last_r;
  logic                     out_last_nxt;
  logic                     skid_valid_r;
  logic                     skid_valid_nxt;
  logic [OUT_TDATA_W-1:0]   skid_data_r;
  logic [OUT_TDATA_W-1:0]   skid_data_nxt;
  logic                     skid_last_r;
  logic                     skid_last_nxt;

  logic [WW-1:0]          eff_w;
  logic [WW-1:0]          w_last;
  logic [RW-1:0]          eff_h;
  logic [RW-1:0]          h_last;
  logic                   cfg_we;
  logic                   acc;
  logic                   pend_zero;
  logic                   cell_push;
  logic                   flush_push;
  logic                   push;
  logic                   push_bit;
  logic                   first_col;
  logic                   at_col_last;
  logic                   at_last;
  logic                   emit;
  logic                   produce;
  logic                   last_flush;
  logic                   stream_clear;
  logic                   pop;
  logic                   next_alive;
  logic [STORE_W-1:0]     tail;
  logic [STORE_W-1:0]     old;
  logic [STORE_W-1:0]     store_in;
  logic [2:0]             column;
  logic [CW-1:0]          ins_idx;
  logic [RW-1:0]          orow;
  logic [WW-1:0]          ocol;
  logic [OUT_TDATA_W-1:0] res_data;
  win_ctl_t               win_ctl;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_GRID_WIDTH:  cfg_prdata = CFG_DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: cfg_prdata = CFG_DATA_W'(grid_height_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_paddr[2])
        REG_GRID_WIDTH:  grid_width_r  <= cfg_pwdata[GRID_WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_pwdata[GRID_HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      eff_h = RW'(1);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(grid_height_r);
    end
  end

  assign w_last  = eff_w - WW'(1);
  assign h_last  = eff_h - RW'(1);
  assign ins_idx = CW'(32'(MAX_WIDTH) - 32'(eff_w));

  // Stream control.
  assign in_tready   = !skid_valid_r && !bubble_r;
  assign acc         = in_tvalid && in_tready;
  assign pend_zero   = (pend_r == '0);
  assign cell_push   = acc && (in_tuser[0] == CMD_CELL) && pend_zero;
  assign flush_push  = acc && (in_tuser[0] == CMD_FLUSH) && !pend_zero;
  assign push        = cell_push || flush_push || bubble_r;
  assign push_bit    = cell_push && in_tdata[0];
  assign first_col   = (col_r == '0);
  assign at_col_last = (WW'(col_r) == w_last);
  assign at_last     = (row_r == h_last) && at_col_last;
  assign emit        = (row_r >= RW'(2)) || ((row_r == RW'(1)) && !first_col);
  assign produce     = push && emit;
  assign last_flush  = flush_push && (pend_r == PW'(1));
  assign stream_clear = cfg_we || last_flush;

  assign old      = (row_r != '0) ? tail : '0;
  assign column   = {push_bit, old[0], old[1]};
  assign store_in = {old[0], push_bit};

  lgs_row_chain #(
    .DEPTH (MAX_WIDTH)
  ) u_row_chain (
    .clk      (clk),
    .shift_en (push),
    .ins_idx  (ins_idx),
    .store_in (store_in),
    .tail     (tail)
  );

  assign win_ctl.push      = push;
  assign win_ctl.clear     = stream_clear;
  assign win_ctl.first_col = first_col;
  assign win_ctl.left_ok   = (col_r >= CW'(2));
  assign win_ctl.wide      = (eff_w >= WW'(2));

  lgs_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (win_ctl),
    .column     (column),
    .next_alive (next_alive)
  );

  assign orow     = first_col ? (row_r - RW'(2)) : (row_r - RW'(1));
  assign ocol     = first_col ? w_last : (WW'(col_r) - WW'(1));
  assign res_data = {{OUT_PAD_W{1'b0}}, OUT_COL_W'(ocol), OUT_ROW_W'(orow), next_alive};

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    pend_nxt   = pend_r;
    bubble_nxt = bubble_r;
    if (stream_clear) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (push) begin
      if (at_col_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
      if (cell_push && at_last) begin
        pend_nxt = (eff_h == RW'(1)) ? PW'(eff_w) : (PW'(eff_w) + PW'(1));
      end else if (flush_push) begin
        pend_nxt = pend_r - PW'(1);
      end
    end
    if (cfg_we) begin
      bubble_nxt = 1'b0;
    end else if (cell_push && at_last && (eff_h == RW'(1))) begin
      bubble_nxt = 1'b1;
    end else if (bubble_r) begin
      bubble_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      pend_r   <= '0;
      bubble_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_r   <= pend_nxt;
      bubble_r <= bubble_nxt;
    end
  end

  // Output register with one skid entry.
  assign pop = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_last_nxt  = skid_last_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      if (out_valid_r && !pop) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res_data;
        skid_last_nxt  = last_flush;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
        out_last_nxt  = last_flush;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    skid_data_r <= skid_data_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/lgs_cell.sv */
// One two-bit cell of the row delay chain, loading new data or taking its neighbor's.
module lgs_cell import lgs_pkg::*; (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               load,
  input  logic [STORE_W-1:0] load_data,
  input  logic [STORE_W-1:0] chain_in,
  output logic [STORE_W-1:0] q
);

  logic [STORE_W-1:0] cell_r;
  logic [STORE_W-1:0] cell_nxt;

  assign cell_nxt = load ? load_data : chain_in;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_r <= cell_nxt;
    end
  end

  assign q = cell_r;

endmodule

/* sv/lgs_row_chain.sv */
// Row delay chain of cells whose effective length follows the grid width.
module lgs_row_chain import lgs_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic [$clog2(DEPTH)-1:0] ins_idx,
  input  logic [STORE_W-1:0]       store_in,
  output logic [STORE_W-1:0]       tail
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [STORE_W-1:0] link [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [STORE_W-1:0] from_left;
    if (k == 0) begin : g_head
      assign from_left = store_in;
    end else begin : g_body
      assign from_left = link[k-1];
    end
    lgs_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load      (ins_idx == IDX_W'(k)),
      .load_data (store_in),
      .chain_in  (from_left),
      .q         (link[k])
    );
  end

  assign tail = link[DEPTH-1];

endmodule

/* sv/lgs_window.sv */
// Three by three neighborhood window and the B3/S23 rule.
module lgs_window import lgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  win_ctl_t   ctl,
  input  logic [2:0] column,
  output logic       next_alive
);

  logic [8:0] window_r;
  logic [8:0] window_nxt;
  logic [8:0] shifted;
  logic [2:0] lc;
  logic [2:0] cc;
  logic [2:0] rc;
  logic [3:0] count;

  assign shifted = {column, window_r[8:3]};

  always_comb begin
    if (ctl.first_col) begin
      lc = ctl.wide ? window_r[5:3] : 3'b000;
      cc = window_r[8:6];
      rc = 3'b000;
    end else begin
      lc = ctl.left_ok ? shifted[2:0] : 3'b000;
      cc = shifted[5:3];
      rc = shifted[8:6];
    end
    count = 4'(lc[0]) + 4'(lc[1]) + 4'(lc[2]) + 4'(rc[0]) + 4'(rc[1]) + 4'(rc[2])
          + 4'(cc[0]) + 4'(cc[2]);
    next_alive = (count == 4'd3) || (cc[1] && (count == 4'd2));
  end

  always_comb begin
    if (ctl.clear) begin
      window_nxt = '0;
    end else if (ctl.push) begin
      window_nxt = shifted;
    end else begin
      window_nxt = window_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

endmodule

/* sv/lgs_checker.sv */
// Port-level checker of the life generation stream unit and its bind.
`include "life_generation_stream_unit_assert.svh"

module lgs_checker import lgs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A new result only follows an accepted item.
  `LGS_ASSERT_NOW(a_result_needs_item, $rose(out_tvalid), $past(in_tvalid && in_tready))

  // The input side only stalls while a result waits or right after an accepted item.
  `LGS_ASSERT_NOW(a_stall_has_cause, !in_tready,
                  out_tvalid || $past(in_tvalid && in_tready))

  `LGS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind life_generation_stream_unit lgs_checker u_lgs_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench of the life generation stream unit, with its scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lgs_pkg::*;

  localparam int GRID_MAX_W    = 256;
  localparam int GRID_MAX_H    = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic                 alive;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } cell_result_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class life_scoreboard;
    logic [GRID_WIDTH_W-1:0]  width_reg;
    logic [GRID_HEIGHT_W-1:0] height_reg;
    bit [STORE_W-1:0]         col_hist [GRID_MAX_W];
    bit [8:0]                 win;
    int unsigned              col_pos, row_pos, owed, errors;
    cell_result_t             next_states[$];

    function new();
      width_reg  = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      foreach (col_hist[i]) col_hist[i] = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      win     = '0;
      col_pos = 0;
      row_pos = 0;
      owed    = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > GRID_MAX_W) return GRID_MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > GRID_MAX_H) return GRID_MAX_H;
      return height_reg;
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_GRID_WIDTH) begin
        width_reg = value[GRID_WIDTH_W-1:0];
      end else begin
        height_reg = value[GRID_HEIGHT_W-1:0];
      end
      clear_frame();
    endfunction

    // Shifts one cell into the 3x3 window and returns 1 when a cell result is due.
    function bit shift_cell(bit cell_bit, int unsigned w, output cell_result_t res);
      int unsigned r, c, n;
      bit emit;
      bit [2:0] lc, cc, rc, column;
      bit [1:0] old;
      r = row_pos;
      c = col_pos;
      emit = (r >= 2) || (r == 1 && c >= 1);
      lc = '0;
      cc = '0;
      rc = '0;
      old = '0;
      res = '0;
      if (emit && c == 0) begin
        lc = (w >= 2) ? win[5:3] : 3'b000;
        cc = win[8:6];
        res.row = OUT_ROW_W'(r - 2);
        res.col = OUT_COL_W'(w - 1);
      end
      if (r != 0) old = col_hist[c];
      column = {cell_bit, old[0], old[1]};
      col_hist[c] = {old[0], cell_bit};
      win = {column, win[8:3]};
      if (emit && c >= 1) begin
        lc = (c >= 2) ? win[2:0] : 3'b000;
        cc = win[5:3];
        rc = win[8:6];
        res.row = OUT_ROW_W'(r - 1);
        res.col = OUT_COL_W'(c - 1);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
      n = $countones(lc) + $countones(rc) + cc[0] + cc[2];
      res.alive = (n == 3) || (cc[1] && n == 2);
      return emit;
    endfunction

    function void take_item(logic cmd, logic cell_bit);
      int unsigned w, h, total;
      bit at_end;
      cell_result_t res;
      w = eff_width();
      h = eff_height();
      if (cmd == CMD_CELL) begin
        if (owed != 0) return;
        at_end = (row_pos == h - 1) && (col_pos == w - 1);
        if (shift_cell(cell_bit, w, res)) next_states = {next_states, res};
        if (at_end) begin
          total = h * w;
          owed = (total < w + 1) ? total : w + 1;
        end
      end else if (owed != 0) begin
        for (int t = 0; t < 3; t++) begin
          if (shift_cell(1'b0, w, res)) begin
            owed--;
            res.last = (owed == 0);
            next_states = {next_states, res};
            if (owed == 0) clear_frame();
            return;
          end
        end
        clear_frame();
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (next_states.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: alive=%0d row=%0d col=%0d last=%0d",
                   got.alive, got.row, got.col, got.last);
        end
        return;
      end
      want = next_states.pop_front();
      if (got.alive !== want.alive || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch: expected alive=%0d row=%0d col=%0d last=%0d",
                   want.alive, want.row, want.col, want.last);
          $display("          actual   alive=%0d row=%0d col=%0d last=%0d",
                   got.alive, got.row, got.col, got.last);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [0] cell_alive, [7:1] zero
  logic [0:0]             in_tuser = '0;   // [0] command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [0] next_alive, [12:1] out_row, [20:13] out_col
  logic                   out_tlast;

  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    quiet_cycles = 0;
  life_scoreboard sb = new();

  life_generation_stream_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result({out_tdata[0], out_tdata[OUT_ROW_W:1],
                       out_tdata[OUT_ROW_W+OUT_COL_W:OUT_ROW_W+1], out_tlast});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void set_idle(idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 83 : (mode == IDLE_BOTH) ? 28 : 0;
    stall_pct     = (mode == IDLE_RECEIVER) ? 83 : (mode == IDLE_BOTH) ? 28 : 0;
  endfunction

  task automatic send_item(input logic cmd, input logic cell_bit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, cell_bit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(cmd, cell_bit);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                           input logic [CFG_DATA_W-1:0] height_val);
    logic                  idx;
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i < 2; i++) begin
      idx   = (i == 0) ? REG_GRID_WIDTH : REG_GRID_HEIGHT;
      value = (i == 0) ? width_val : height_val;
      cfg_psel    <= 1'b1;
      cfg_pwrite  <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_paddr   <= {idx, 2'b00};
      cfg_pwdata  <= value;
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      sb.write_reg(idx, value);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.next_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly whole frames and drains; stray flushes and cells dropped during a drain are noise.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] width_val,
                           input logic [CFG_DATA_W-1:0] height_val,
                           input idle_mode_t mode, input int unsigned budget);
    int unsigned sent, live_pct;
    settle();
    configure(width_val, height_val);
    set_idle(mode);
    live_pct = $urandom_range(15, 60);
    sent = 0;
    while (sent < budget) begin
      if (sb.owed == 0) begin
        if ($urandom_range(99) < 3) begin
          send_item(CMD_FLUSH, 1'($urandom_range(1)));
        end else begin
          send_item(CMD_CELL, $urandom_range(99) < live_pct);
          sent++;
        end
      end else if ($urandom_range(99) < 8) begin
        send_item(CMD_CELL, 1'($urandom_range(1)));
      end else begin
        send_item(CMD_FLUSH, 1'($urandom_range(1)));
        sent++;
      end
      if ($urandom_range(499) == 0) settle();
    end
  endtask

  initial begin
    set_idle(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_CELL, 1'b1);
    send_item(CMD_FLUSH, 1'b0);

    settle();
    configure(3, 3);
    for (int i = 0; i < 9; i++) send_item(CMD_CELL, (i % 3) == 1);
    send_item(CMD_CELL, 1'b1);
    repeat (4) send_item(CMD_FLUSH, 1'b1);
    send_item(CMD_FLUSH, 1'b0);

    settle();
    configure(0, 0);
    send_item(CMD_CELL, 1'b1);
    send_item(CMD_FLUSH, 1'b0);
    send_item(CMD_FLUSH, 1'b1);

    settle();
    configure(2, 2);
    repeat (4) send_item(CMD_CELL, 1'b1);
    repeat (3) send_item(CMD_FLUSH, 1'b0);

    run_phase(5, 4, IDLE_NONE, 120);
    run_phase(32'hFFFF_FE04, 32'hFFFF_E003, IDLE_SENDER, 180);
    run_phase(3, 3, IDLE_RECEIVER, 120);
    run_phase(9, 6, IDLE_BOTH, 180);
    run_phase(511, 1, IDLE_RECEIVER, 512);
    run_phase(0, 8191, IDLE_SENDER, 120);
    run_phase(2, 0, IDLE_BOTH, 80);
    repeat (4) begin
      run_phase($urandom_range(1, 12), $urandom_range(1, 8),
                idle_mode_t'($urandom_range(3)), $urandom_range(40, 60));
    end

    settle();
    if (sb.errors == 0 && sb.next_states.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
